### sv/packet_impairment_scheduler_top_defines.svh
// Assertion macros shared by the packet impairment scheduler RTL.
`ifndef PACKET_IMPAIRMENT_SCHEDULER_TOP_DEFINES_SVH
`define PACKET_IMPAIRMENT_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication under the asynchronous reset.
`define PIS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pis assertion failed");

// Next-cycle implication under the asynchronous reset.
`define PIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pis assertion failed");

`endif

### sv/pis_pkg.sv
// Types, constants and helper functions of the packet impairment scheduler.
`default_nettype none
package pis_pkg;

	localparam int NODE_COUNT = 4;
	localparam int SLOT_COUNT = 32;
	localparam int TAG_BITS   = 16;

	localparam int NODE_W    = 2;
	localparam int TAG_W     = 16;
	localparam int TICK_W    = 32;
	localparam int RNG_W     = 64;
	localparam int THR_W     = 17;
	localparam int DELAY_W   = 8;
	localparam int PAIR_BITS = NODE_COUNT * (NODE_COUNT - 1) / 2;
	localparam int KIND_W    = 2;
	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [RNG_W-1:0] GOLDEN_SEED = 64'h9E3779B97F4A7C15;
	localparam logic [RNG_W-1:0] MIX_MULT    = 64'h2545F4914F6CDD1D;
	localparam logic [TAG_W-1:0] TAG_MASK    = TAG_W'((65'd1 << TAG_BITS) - 65'd1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEED = 3'd0,
		CFG_DROP = 3'd1,
		CFG_DUP  = 3'd2,
		CFG_MAXD = 3'd3,
		CFG_PART = 3'd4
	} cfg_reg_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_SEND  = 2'd0,
		KIND_DELIV = 2'd1,
		KIND_TICK  = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_PART_DROP = 3'd0,
		ST_RAND_DROP = 3'd1,
		ST_SCHED     = 3'd2,
		ST_SCHED_DUP = 3'd3,
		ST_OVERFLOW  = 3'd4
	} status_t;

	typedef enum logic {
		REQ_SEND = 1'b0,
		REQ_TICK = 1'b1
	} req_type_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DROP,
		S_DLY_RNG,
		S_DLY_MOD,
		S_PUSH,
		S_DUP,
		S_SEND_OUT,
		S_TICK_RD,
		S_TICK_EV,
		S_TICK_END
	} pis_state_t;

	typedef struct packed {
		logic [NODE_W-1:0] src;
		logic [NODE_W-1:0] dst;
		logic [TAG_W-1:0]  tag;
		logic [TICK_W-1:0] due;
	} slot_entry_t;

	localparam int ENTRY_W = $bits(slot_entry_t);

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [RNG_W-1:0] draw;
	} rng_stat_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [DELAY_W-1:0] rem;
	} mod_stat_t;

	function automatic logic pair_blocked(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
			logic [PAIR_BITS-1:0] mask);
		logic [NODE_W-1:0] lo;
		logic [NODE_W-1:0] hi;
		logic [7:0] idx;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		idx = 8'(lo) * 8'(NODE_COUNT) - ((8'(lo) * (8'(lo) + 8'd1)) >> 1)
			+ 8'(hi) - 8'(lo) - 8'd1;
		return (a != b) && (idx < 8'(PAIR_BITS)) && mask[idx[$clog2(PAIR_BITS)-1:0]];
	endfunction

	function automatic logic [RNG_W-1:0] xorshift(logic [RNG_W-1:0] x);
		logic [RNG_W-1:0] t;
		t = x ^ (x >> 12);
		t = t ^ (t << 25);
		t = t ^ (t >> 27);
		return t;
	endfunction

endpackage
`default_nettype wire

### sv/pis_req_if.sv
// Request channel of the packet impairment scheduler.
`default_nettype none
interface pis_req_if;
	import pis_pkg::*;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [NODE_W-1:0] src_node;
	logic [NODE_W-1:0] dst_node;
	logic [TAG_W-1:0]  msg_tag;

	modport source (output valid, req_type, src_node, dst_node, msg_tag, input ready);
	modport sink (input valid, req_type, src_node, dst_node, msg_tag, output ready);
endinterface
`default_nettype wire

### sv/pis_rsp_if.sv
// Result channel of the packet impairment scheduler.
`default_nettype none
interface pis_rsp_if;
	import pis_pkg::*;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [STATUS_W-1:0] status;
	logic [NODE_W-1:0]   out_src;
	logic [NODE_W-1:0]   out_dst;
	logic [TAG_W-1:0]    out_tag;
	logic                last;

	modport source (output valid, kind, status, out_src, out_dst, out_tag, last, input ready);
	modport sink (input valid, kind, status, out_src, out_dst, out_tag, last, output ready);
endinterface
`default_nettype wire

### sv/packet_impairment_scheduler_top.sv
// Top level of the packet impairment scheduler.
// A send request dropped by the partition mask goes straight to the result state;
// otherwise each random draw runs through the shared 32x32 multiplier, and each delay
// draw adds a pass through the two-bit-per-cycle remainder unit, with at most four draws
// and two remainders per send. A tick request walks the slot memory entry by entry:
// it reads each stored entry, then evaluates it and writes back the entries not yet due;
// a delivered entry also waits for the result port. Requests are taken only while the
// sequencer is idle; one result register decouples the result port.
`default_nettype none
`include "packet_impairment_scheduler_top_defines.svh"
module packet_impairment_scheduler_top #(
	parameter int SLOT_COUNT = pis_pkg::SLOT_COUNT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	pis_req_if.sink                             req,
	pis_rsp_if.source                           rsp,
	input  wire logic                           cfg_we,
	input  wire logic [pis_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [pis_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pis_pkg::*;

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);

	pis_state_t state_q, state_d;

	logic [THR_W-1:0]     drop_thr_q;
	logic [THR_W-1:0]     dup_thr_q;
	logic [DELAY_W-1:0]   max_dly_q;
	logic [PAIR_BITS-1:0] part_q;

	logic [TICK_W-1:0] tick_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  keep_q;
	logic [NODE_W-1:0] src_q;
	logic [NODE_W-1:0] dst_q;
	logic [TAG_W-1:0]  tag_q;
	logic              dup_phase_q;
	logic              ok_q;
	status_t           status_q;

	logic                out_valid_q;
	logic [KIND_W-1:0]   out_kind_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [NODE_W-1:0]   out_src_q;
	logic [NODE_W-1:0]   out_dst_q;
	logic [TAG_W-1:0]    out_tag_q;
	logic                out_last_q;

	rng_stat_t rng_st;
	mod_stat_t mod_st;

	logic              req_fire;
	logic              out_free;
	logic              blocked;
	logic              drop_hit;
	logic              dup_hit;
	logic              fits;
	logic              has_dly;
	logic              rng_start;
	logic              mod_start;
	logic              seed_load;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	slot_entry_t       ram_wdata;
	logic              ram_re;
	logic [ENTRY_W-1:0] ram_rdata;
	slot_entry_t       entry;
	logic              entry_due;
	logic              walk_last;
	logic              out_load;
	kind_t             out_kind_d;
	status_t           out_status_d;
	logic              out_last_d;
	logic [TICK_W-1:0] due_diff;

	assign req_fire  = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign blocked   = pair_blocked(req.src_node, req.dst_node, part_q);
	assign drop_hit  = {1'b0, rng_st.draw[63:48]} < drop_thr_q;
	assign dup_hit   = {1'b0, rng_st.draw[63:48]} < dup_thr_q;
	assign fits      = count_q < CNT_W'(SLOT_COUNT);
	assign has_dly   = max_dly_q != '0;
	assign seed_load = cfg_we && (cfg_addr == CFG_SEED);
	assign entry     = slot_entry_t'(ram_rdata);
	assign due_diff  = tick_q - entry.due;
	assign entry_due = !due_diff[TICK_W-1];
	assign walk_last = (idx_q + CNT_W'(1)) == count_q;
	assign req.ready = state_q == S_IDLE;

	pis_rng u_rng (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (seed_load),
		.seed   (cfg_data),
		.start  (rng_start),
		.stat   (rng_st)
	);

	pis_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (rng_st.draw),
		.divisor  ((DELAY_W + 1)'(max_dly_q) + (DELAY_W + 1)'(1)),
		.stat     (mod_st)
	);

	pis_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOT_COUNT)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					if (req.req_type == REQ_TICK) begin
						state_d = (count_q == '0) ? S_TICK_END : S_TICK_RD;
					end else begin
						state_d = blocked ? S_SEND_OUT : S_DROP;
					end
				end
			end
			S_DROP: begin
				if (rng_st.done) begin
					state_d = drop_hit ? S_SEND_OUT : (has_dly ? S_DLY_RNG : S_PUSH);
				end
			end
			S_DLY_RNG: begin
				if (rng_st.done) begin
					state_d = S_DLY_MOD;
				end
			end
			S_DLY_MOD: begin
				if (mod_st.done) begin
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				state_d = dup_phase_q ? S_SEND_OUT : S_DUP;
			end
			S_DUP: begin
				if (rng_st.done) begin
					state_d = dup_hit ? (has_dly ? S_DLY_RNG : S_PUSH) : S_SEND_OUT;
				end
			end
			S_SEND_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_TICK_RD: begin
				state_d = S_TICK_EV;
			end
			S_TICK_EV: begin
				if (!entry_due || out_free) begin
					state_d = walk_last ? S_TICK_END : S_TICK_RD;
				end
			end
			S_TICK_END: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		rng_start    = 1'b0;
		mod_start    = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = count_q[IDX_W-1:0];
		ram_wdata    = entry;
		ram_re       = 1'b0;
		out_load     = 1'b0;
		out_kind_d   = KIND_SEND;
		out_status_d = status_q;
		out_last_d   = 1'b1;
		case (state_q)
			S_IDLE: begin
				rng_start = req_fire && (req.req_type == REQ_SEND) && !blocked;
			end
			S_DROP: begin
				rng_start = rng_st.done && !drop_hit && has_dly;
			end
			S_DLY_RNG: begin
				mod_start = rng_st.done;
			end
			S_PUSH: begin
				ram_we        = fits;
				ram_wdata.src = src_q;
				ram_wdata.dst = dst_q;
				ram_wdata.tag = tag_q;
				ram_wdata.due = tick_q + TICK_W'(1) + (has_dly ? TICK_W'(mod_st.rem) : '0);
				rng_start     = !dup_phase_q;
			end
			S_DUP: begin
				rng_start = rng_st.done && dup_hit && has_dly;
			end
			S_SEND_OUT: begin
				out_load = out_free;
			end
			S_TICK_RD: begin
				ram_re = 1'b1;
			end
			S_TICK_EV: begin
				ram_waddr = keep_q[IDX_W-1:0];
				ram_we    = !entry_due;
				out_load  = entry_due && out_free;
				out_kind_d   = KIND_DELIV;
				out_status_d = ST_PART_DROP;
				out_last_d   = 1'b0;
			end
			S_TICK_END: begin
				out_load     = out_free;
				out_kind_d   = KIND_TICK;
				out_status_d = ST_PART_DROP;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			drop_thr_q  <= '0;
			dup_thr_q   <= '0;
			max_dly_q   <= '0;
			part_q      <= '0;
			tick_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			keep_q      <= '0;
			dup_phase_q <= 1'b0;
			ok_q        <= 1'b0;
			status_q    <= ST_PART_DROP;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_addr)
					CFG_DROP: drop_thr_q <= cfg_data[THR_W-1:0];
					CFG_DUP:  dup_thr_q  <= cfg_data[THR_W-1:0];
					CFG_MAXD: max_dly_q  <= cfg_data[DELAY_W-1:0];
					CFG_PART: part_q     <= cfg_data[PAIR_BITS-1:0];
					default: begin
					end
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						idx_q       <= '0;
						keep_q      <= '0;
						dup_phase_q <= 1'b0;
						ok_q        <= 1'b1;
						status_q    <= ST_PART_DROP;
						if (req.req_type == REQ_TICK) begin
							tick_q <= tick_q + TICK_W'(1);
						end
					end
				end
				S_DROP: begin
					if (rng_st.done && drop_hit) begin
						status_q <= ST_RAND_DROP;
					end
				end
				S_PUSH: begin
					if (fits) begin
						count_q <= count_q + CNT_W'(1);
					end else begin
						ok_q <= 1'b0;
					end
					if (dup_phase_q) begin
						status_q <= (ok_q && fits) ? ST_SCHED_DUP : ST_OVERFLOW;
					end
				end
				S_DUP: begin
					if (rng_st.done) begin
						if (dup_hit) begin
							dup_phase_q <= 1'b1;
						end else begin
							status_q <= ok_q ? ST_SCHED : ST_OVERFLOW;
						end
					end
				end
				S_TICK_EV: begin
					if (!entry_due || out_free) begin
						idx_q <= idx_q + CNT_W'(1);
						if (!entry_due) begin
							keep_q <= keep_q + CNT_W'(1);
						end
					end
				end
				S_TICK_END: begin
					if (out_free) begin
						count_q <= keep_q;
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			src_q <= req.src_node;
			dst_q <= req.dst_node;
			tag_q <= req.msg_tag & TAG_MASK;
		end
		if (out_load) begin
			out_kind_q   <= out_kind_d;
			out_status_q <= out_status_d;
			out_last_q   <= out_last_d;
			if (out_kind_d == KIND_DELIV) begin
				out_src_q <= entry.src;
				out_dst_q <= entry.dst;
				out_tag_q <= entry.tag;
			end else begin
				out_src_q <= '0;
				out_dst_q <= '0;
				out_tag_q <= '0;
			end
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.kind    = out_kind_q;
	assign rsp.status  = out_status_q;
	assign rsp.out_src = out_src_q;
	assign rsp.out_dst = out_dst_q;
	assign rsp.out_tag = out_tag_q;
	assign rsp.last    = out_last_q;

	`PIS_ASSERT_IMPLY(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(SLOT_COUNT))
	`PIS_ASSERT_IMPLY(a_keep_behind, clk, arst_n, state_q == S_TICK_EV, keep_q <= idx_q)
	`PIS_ASSERT_IMPLY(a_idle_quiet, clk, arst_n, state_q == S_IDLE, !rng_st.busy && !mod_st.busy)
	`PIS_ASSERT_NEXT(a_end_to_idle, clk, arst_n, (state_q == S_TICK_END) && out_free, state_q == S_IDLE)
endmodule
`default_nettype wire

### sv/pis_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module pis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

### sv/pis_rng.sv
// xorshift64* generator with a shared 32x32 multiplier stepped through the partial products.
`default_nettype none
module pis_rng (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      load,
	input  wire logic [pis_pkg::RNG_W-1:0] seed,
	input  wire logic                      start,
	output pis_pkg::rng_stat_t             stat
);
	import pis_pkg::*;

	logic [RNG_W-1:0] word_q;
	logic [RNG_W-1:0] acc_q;
	logic [1:0]       step_q;
	logic             busy_q;
	logic             done_q;
	logic [31:0]      op_a;
	logic [31:0]      op_b;
	logic [63:0]      prod;

	always_comb begin
		op_a = (step_q == 2'd1) ? word_q[63:32] : word_q[31:0];
		op_b = (step_q == 2'd2) ? MIX_MULT[63:32] : MIX_MULT[31:0];
		prod = 64'(op_a) * 64'(op_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= GOLDEN_SEED;
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				word_q <= (seed != '0) ? seed : GOLDEN_SEED;
			end else if (start) begin
				word_q <= xorshift(word_q);
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (step_q == 2'd0) begin
				acc_q <= prod;
			end else begin
				acc_q[63:32] <= acc_q[63:32] + prod[31:0];
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.draw = acc_q;
endmodule
`default_nettype wire

### sv/pis_mod.sv
// Serial remainder unit, two dividend bits per cycle.
`default_nettype none
module pis_mod (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [pis_pkg::RNG_W-1:0]   dividend,
	input  wire logic [pis_pkg::DELAY_W:0]   divisor,
	output pis_pkg::mod_stat_t               stat
);
	import pis_pkg::*;

	localparam int STEPS = RNG_W / 2;
	localparam int CNT_W = $clog2(STEPS);

	logic [RNG_W-1:0]   dvd_q;
	logic [DELAY_W:0]   dsr_q;
	logic [DELAY_W-1:0] rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DELAY_W:0]   t0;
	logic [DELAY_W:0]   t1;
	logic [DELAY_W-1:0] r0;
	logic [DELAY_W-1:0] r1;

	always_comb begin
		t0 = {rem_q, dvd_q[RNG_W-1]};
		r0 = (t0 >= dsr_q) ? DELAY_W'(t0 - dsr_q) : DELAY_W'(t0);
		t1 = {r0, dvd_q[RNG_W-2]};
		r1 = (t1 >= dsr_q) ? DELAY_W'(t1 - dsr_q) : DELAY_W'(t1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 2;
			rem_q <= r1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.rem  = rem_q;
endmodule
`default_nettype wire
